### rtl/core/lzte_pkg.sv
package lzte_pkg;

  // Default limits for lengths and distances.
  localparam int unsigned MAX_RUN_DEF      = 16383;
  localparam int unsigned MAX_DISTANCE_DEF = 32767;

  // Field widths.
  localparam int unsigned PEND_W = 14;
  localparam int unsigned DATA_W = 16;
  localparam int unsigned OVH_W  = 17;

  // Input item modes.
  localparam logic [1:0] MODE_RUN = 2'd0;
  localparam logic [1:0] MODE_LIT = 2'd1;
  localparam logic [1:0] MODE_MATCH = 2'd2;
  localparam logic [1:0] MODE_END = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_LEN  = 2'd1;
  localparam logic [1:0] ST_BAD_DIST = 2'd2;
  localparam logic [1:0] ST_UNANN    = 2'd3;

  // Stream state carried from item to item.
  typedef struct packed {
    logic [PEND_W-1:0] pending;
    logic [DATA_W-1:0] data_cnt;
    logic [OVH_W-1:0]  ovh_cnt;
  } stream_t;

  // Encoded bytes of one item, ready for serialization.
  typedef struct packed {
    logic [3:0][7:0]  bytes;
    logic [1:0]       last_idx;
    logic [1:0]       status;
    logic [DATA_W-1:0] data_total;
    logic [OVH_W-1:0]  ovh_total;
  } token_t;

endpackage

### rtl/core/lz_token_stream_encoder_top.sv
// The first byte of an item passes from the token register to the output register after acceptance.
// Throughput: one output byte per cycle while out_ready_i is not held low; an item has 1 to 4 bytes.
// Items of one byte each are taken every cycle while the output is not stalled; the byte serializer sets the rate.
// Reset clears all valid flags, the pending literal count and the data count,
// and sets the overhead count to one for the end mark.
module lz_token_stream_encoder_top #(
  parameter int unsigned MaxRun      = lzte_pkg::MAX_RUN_DEF,
  parameter int unsigned MaxDistance = lzte_pkg::MAX_DISTANCE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] item_length_i,
  input  logic [15:0] match_distance_i,
  input  logic [7:0]  literal_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_of_item_o,
  output logic [1:0]  status_o,
  output logic [15:0] data_total_o,
  output logic [16:0] overhead_total_o
);

  lzte_pkg::stream_t stream_q, stream_d;
  lzte_pkg::token_t  tok_q, tok_d;
  logic              tok_valid_q;
  logic [1:0]        idx_q;
  logic              out_valid_q;
  logic              in_accept;
  logic              out_load;
  logic              load_last;

  // Item encoder in front of the token register.
  lzte_encode #(
    .MaxRun      (MaxRun),
    .MaxDistance (MaxDistance)
  ) u_encode (
    .mode_i           (mode_i),
    .item_length_i    (item_length_i),
    .match_distance_i (match_distance_i),
    .literal_value_i  (literal_value_i),
    .state_i          (stream_q),
    .state_o          (stream_d),
    .token_o          (tok_d)
  );

  // Handshake: the output register takes a byte whenever it is free or drained.
  assign out_load   = tok_valid_q && (!out_valid_q || out_ready_i);
  assign load_last  = out_load && (idx_q == tok_q.last_idx);
  assign in_ready_o = !tok_valid_q || load_last;
  assign in_accept  = in_valid_i && in_ready_o;

  // Control state and stream state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_q    <= '{pending: '0, data_cnt: '0, ovh_cnt: lzte_pkg::OVH_W'(1)};
      tok_valid_q <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        stream_q <= stream_d;
      end
      if (in_accept) begin
        tok_valid_q <= 1'b1;
      end else if (load_last) begin
        tok_valid_q <= 1'b0;
      end
      if (load_last) begin
        idx_q <= 2'd0;
      end else if (out_load) begin
        idx_q <= idx_q + 2'd1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: encoded token and the output byte with its fields.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      tok_q <= tok_d;
    end
    if (out_load) begin
      out_byte_o       <= tok_q.bytes[idx_q];
      last_of_item_o   <= (idx_q == tok_q.last_idx);
      status_o         <= tok_q.status;
      data_total_o     <= tok_q.data_total;
      overhead_total_o <= tok_q.ovh_total;
    end
  end

  assign out_valid_o = out_valid_q;

  // An error result always stands alone as the last byte of its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != lzte_pkg::ST_OK) |-> last_of_item_o)
    else $error("error result not marked as last of item");

  // Totals appear only on the final byte of an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_item_o |-> (data_total_o == '0) && (overhead_total_o == '0))
    else $error("totals on a non-final byte");

  // The serializer index never runs past the token's last byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_q |-> (idx_q <= tok_q.last_idx))
    else $error("serializer index beyond token length");

  // The overhead count always includes the end mark.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stream_q.ovh_cnt != '0)
    else $error("overhead count lost the end mark");

  // A new item is never taken while the current token still has bytes left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && tok_valid_q |-> load_last)
    else $error("token register overwritten before drained");

endmodule

### rtl/core/lzte_encode.sv
module lzte_encode #(
  parameter int unsigned MaxRun      = lzte_pkg::MAX_RUN_DEF,
  parameter int unsigned MaxDistance = lzte_pkg::MAX_DISTANCE_DEF
) (
  input  logic [1:0]        mode_i,
  input  logic [15:0]       item_length_i,
  input  logic [15:0]       match_distance_i,
  input  logic [7:0]        literal_value_i,
  input  lzte_pkg::stream_t state_i,
  output lzte_pkg::stream_t state_o,
  output lzte_pkg::token_t  token_o
);

  logic        len_bad;
  logic        dist_bad;
  logic        len_short;
  logic        off_short;
  logic        flag;
  logic [7:0]  len_b0;
  logic [7:0]  len_b1;
  logic [15:0] neg;
  logic [7:0]  off_b0;
  logic [7:0]  off_b1;
  logic [2:0]  n_tok;
  logic [17:0] ovh_sum;

  // Range checks on the length and distance fields.
  assign len_bad  = (item_length_i == 16'd0) || (item_length_i > 16'(MaxRun));
  assign dist_bad = (match_distance_i == 16'd0) ||
                    (match_distance_i > 16'(MaxDistance));

  // Length token: one byte below 64, otherwise a flagged high byte and a low byte.
  assign len_short = item_length_i < 16'd64;
  assign flag      = (mode_i == lzte_pkg::MODE_MATCH);
  assign len_b0    = len_short ? {item_length_i[6:0], flag}
                               : {1'b1, item_length_i[13:8], flag};
  assign len_b1    = item_length_i[7:0];

  // Offset token from the negated distance.
  assign neg       = 16'd0 - match_distance_i;
  assign off_short = match_distance_i < 16'd128;
  assign off_b0    = off_short ? {neg[6:0], 1'b0} : {neg[14:8], 1'b1};
  assign off_b1    = neg[7:0];

  // Token bytes of this item, for the saturating overhead count.
  assign n_tok   = (mode_i == lzte_pkg::MODE_MATCH)
                 ? 3'd2 + {2'b00, ~len_short} + {2'b00, ~off_short}
                 : 3'd1 + {2'b00, ~len_short};
  assign ovh_sum = {1'b0, state_i.ovh_cnt} + 18'(n_tok);

  // Encode one item and work out the next stream state.
  always_comb begin
    token_o = '0;
    state_o = state_i;
    unique case (mode_i)
      lzte_pkg::MODE_RUN: begin
        if (len_bad) begin
          token_o.status = lzte_pkg::ST_BAD_LEN;
        end else begin
          token_o.bytes[0] = len_b0;
          token_o.bytes[1] = len_b1;
          token_o.last_idx = len_short ? 2'd0 : 2'd1;
          state_o.pending  = item_length_i[lzte_pkg::PEND_W-1:0];
          state_o.ovh_cnt  = ovh_sum[17] ? '1 : ovh_sum[lzte_pkg::OVH_W-1:0];
        end
      end
      lzte_pkg::MODE_LIT: begin
        if (state_i.pending == '0) begin
          token_o.status = lzte_pkg::ST_UNANN;
        end else begin
          token_o.bytes[0] = literal_value_i;
          state_o.pending  = state_i.pending - 1'b1;
          if (state_i.data_cnt != '1) begin
            state_o.data_cnt = state_i.data_cnt + 1'b1;
          end
        end
      end
      lzte_pkg::MODE_MATCH: begin
        if (len_bad) begin
          token_o.status = lzte_pkg::ST_BAD_LEN;
        end else if (dist_bad) begin
          token_o.status = lzte_pkg::ST_BAD_DIST;
        end else begin
          token_o.bytes[0] = len_b0;
          if (len_short) begin
            token_o.bytes[1] = off_b0;
            token_o.bytes[2] = off_b1;
            token_o.last_idx = off_short ? 2'd1 : 2'd2;
          end else begin
            token_o.bytes[1] = len_b1;
            token_o.bytes[2] = off_b0;
            token_o.bytes[3] = off_b1;
            token_o.last_idx = off_short ? 2'd2 : 2'd3;
          end
          state_o.ovh_cnt = ovh_sum[17] ? '1 : ovh_sum[lzte_pkg::OVH_W-1:0];
        end
      end
      lzte_pkg::MODE_END: begin
        token_o.data_total = state_i.data_cnt;
        token_o.ovh_total  = state_i.ovh_cnt;
        state_o.pending    = '0;
        state_o.data_cnt   = '0;
        state_o.ovh_cnt    = lzte_pkg::OVH_W'(1);
      end
      default: begin
        token_o = '0;
      end
    endcase
  end

endmodule
